// ----- rtl/core/bfd_pkg.sv -----
// ---------------------------------------------------------------------------
// bfd_pkg: shared types and constants for the box filter downsampler
// Widths, limits, register indexes and the words passed between the
// front end, the band queue and the band accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

	// Line store and level limits
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_LEVEL  = 4;
	localparam int NUM_CH     = 3;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int SUM_W      = 16;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 16;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 16;
	localparam int LEVEL_W    = 3;
	localparam int SHIFT_W    = 4;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int BAND_W     = NUM_CH * SUM_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Band queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Result buffer
	localparam int OBUF_DEPTH  = 2;
	localparam int OPTR_W      = $clog2(OBUF_DEPTH);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SRC_WIDTH  = 2'd0,
		CFG_SRC_HEIGHT = 2'd1,
		CFG_LEVEL      = 2'd2
	} cfg_index_t;

	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum3_t;

	// One finished horizontal block run, to be folded into the line store
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		sum3_t              hsum;
		logic               row_first;
		logic               row_last;
		logic [ROW_W-1:0]   orow;
		logic               last;
		logic [LEVEL_W-1:0] lv;
	} bfd_band_op_t;

	// One output pixel
	typedef struct packed {
		logic [NUM_CH-1:0][PIX_W-1:0] avg;
		logic [COL_W-1:0]             col;
		logic [ROW_W-1:0]             row;
		logic                         last;
	} bfd_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/box_filter_downsample.sv -----
// ---------------------------------------------------------------------------
// box_filter_downsample: power-of-two box filter image shrinker
// Source RGB pixels in raster order come in on the pix channel
// (pix_valid / pix_stall); a word is taken at an edge with pix_valid high
// and pix_stall low. Each output pixel is the truncated mean of an aligned
// 2^level square block and leaves on the res channel (res_valid /
// res_stall) when the bottom-right pixel of its block has been taken.
// Leftover columns and rows beyond the last whole block are dropped.
// Registers src_width, src_height and level are written through the cfg
// channel (cfg_valid / cfg_ready, index and data); the user must do so
// only while the block is idle, which the block itself does not enforce.
// Throughput: one pixel per clock while pix_stall is low. Each block run
// needs one read-modify-write of the single-port-write line store,
// pipelined with forwarding of the previous write. A result word passes
// the band queue, the line store read stage and the result buffer.
// When the receiver stalls, results collect in a two-word buffer; block
// run words then back up in a four-word queue, and only when that queue is
// full does pix_stall rise.
// Reset clears position, run sums and the queues and loads the registers
// with 1024 x 768, level 1. The line store needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module box_filter_downsample import bfd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// source pixels
	input  wire logic                  pix_valid,
	output      logic                  pix_stall,
	input  wire logic [PIX_W-1:0]      red,
	input  wire logic [PIX_W-1:0]      green,
	input  wire logic [PIX_W-1:0]      blue,
	// output pixels
	output      logic                  res_valid,
	input  wire logic                  res_stall,
	output      logic [PIX_W-1:0]      avg_red,
	output      logic [PIX_W-1:0]      avg_green,
	output      logic [PIX_W-1:0]      avg_blue,
	output      logic [COL_W-1:0]      out_col,
	output      logic [ROW_W-1:0]      out_row,
	output      logic                  last_of_image
);

	logic         q_push;
	logic         q_pop;
	logic         q_full;
	logic         q_empty;
	bfd_band_op_t q_wdata;
	bfd_band_op_t q_rdata;
	bfd_result_t  res_word;

	// Intake and horizontal summing
	bfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// Decoupling queue
	bfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// Band accumulation and results
	bfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	assign avg_red       = res_word.avg[0];
	assign avg_green     = res_word.avg[1];
	assign avg_blue      = res_word.avg[2];
	assign out_col       = res_word.col;
	assign out_row       = res_word.row;
	assign last_of_image = res_word.last;

endmodule

`default_nettype wire

// ----- rtl/core/bfd_ram.sv -----
// ---------------------------------------------------------------------------
// bfd_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and shows
// the old contents when a location is read and written in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_front.sv -----
// ---------------------------------------------------------------------------
// bfd_front: pixel intake, position tracking and horizontal summing
// Holds the configuration registers, tracks the source position, sums
// pixels across each block row and queues one word per finished run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_front import bfd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// source pixels
	input  wire logic                  pix_valid,
	output      logic                  pix_stall,
	input  wire logic [PIX_W-1:0]      red,
	input  wire logic [PIX_W-1:0]      green,
	input  wire logic [PIX_W-1:0]      blue,
	// band queue
	input  wire logic                  q_full,
	output      logic                  q_push,
	output      bfd_band_op_t          q_wdata
);

	logic [WIDTH_W-1:0]  src_width_q;
	logic [HEIGHT_W-1:0] src_height_q;
	logic [LEVEL_W-1:0]  level_q;

	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	sum3_t               hsum_q;

	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [LEVEL_W-1:0]  lv;
	logic [ROW_W-1:0]    mask;
	logic [WIDTH_W-1:0]  ow;
	logic [ROW_W-1:0]    oh;
	logic [COL_W-1:0]    ocol;
	logic [ROW_W-1:0]    orow;
	logic                active;
	logic                col_first;
	logic                col_last;
	logic                row_first;
	logic                row_last;
	logic                col_wrap;
	logic                row_wrap;
	logic                accept;
	sum3_t               px;
	sum3_t               hsum_next;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= WIDTH_W'(1024);
			src_height_q <= HEIGHT_W'(768);
			level_q      <= LEVEL_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_LEVEL:      level_q      <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry: zero means one, width and level saturate
	always_comb begin
		if (src_width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (src_width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = src_width_q;
		end
		h_eff = (src_height_q == '0) ? HEIGHT_W'(1) : src_height_q;
		lv    = (level_q > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level_q;
	end

	// Block position of the current pixel
	assign mask      = (ROW_W'(1) << lv) - ROW_W'(1);
	assign ow        = w_eff >> lv;
	assign oh        = h_eff >> lv;
	assign ocol      = col_q >> lv;
	assign orow      = row_q >> lv;
	assign active    = (WIDTH_W'(ocol) < ow) && (orow < oh);
	assign col_first = (col_q & mask[COL_W-1:0]) == '0;
	assign col_last  = (col_q & mask[COL_W-1:0]) == mask[COL_W-1:0];
	assign row_first = (row_q & mask) == '0;
	assign row_last  = (row_q & mask) == mask;
	assign col_wrap  = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= w_eff;
	assign row_wrap  = ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);

	// Horizontal run sum, restarted at the first column of each block
	assign px = {SUM_W'(blue), SUM_W'(green), SUM_W'(red)};
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			hsum_next[k] = col_first ? px[k] : hsum_q[k] + px[k];
		end
	end

	// Handshake: a full band queue holds off the source
	assign pix_stall = q_full;
	assign accept    = pix_valid && !pix_stall;

	// Position counters and run sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			hsum_q <= '0;
		end else if (accept) begin
			if (active) begin
				hsum_q <= hsum_next;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Word for the band accumulator at the end of each block run
	assign q_push = accept && active && col_last;
	always_comb begin
		q_wdata.addr      = ocol[ADDR_W-1:0];
		q_wdata.hsum      = hsum_next;
		q_wdata.row_first = row_first;
		q_wdata.row_last  = row_last;
		q_wdata.orow      = orow;
		q_wdata.last      = (WIDTH_W'(ocol) == ow - WIDTH_W'(1)) && (orow == oh - ROW_W'(1));
		q_wdata.lv        = lv;
	end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_queue.sv -----
// ---------------------------------------------------------------------------
// bfd_queue: short FIFO between front end and band accumulator
// Lets the intake keep taking pixels while the accumulator waits on
// the result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_queue import bfd_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire bfd_band_op_t wdata,
	output      logic         full,
	input  wire logic         pop,
	output      bfd_band_op_t rdata,
	output      logic         empty
);

	bfd_band_op_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;

	assign full  = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign rdata = entry_q[rd_ptr_q];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bfd_back.sv -----
// ---------------------------------------------------------------------------
// bfd_back: band accumulator and result buffer
// Read-modify-write of the per-column band sums in the line store, with
// forwarding of the previous write, and a two-word result buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfd_back import bfd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// band queue
	input  wire logic               q_empty,
	input  wire bfd_band_op_t       q_rdata,
	output      logic               q_pop,
	// results
	output      logic               res_valid,
	input  wire logic               res_stall,
	output      bfd_result_t        res_word
);

	logic               valid_s1;
	bfd_band_op_t       op_s1;

	logic               fwd_valid_q;
	logic [ADDR_W-1:0]  fwd_addr_q;
	sum3_t              fwd_data_q;

	bfd_result_t        obuf_q [OBUF_DEPTH];
	logic [OPTR_W-1:0]  owr_ptr_q;
	logic [OPTR_W-1:0]  ord_ptr_q;
	logic [OPTR_W:0]    ocount_q;

	logic [BAND_W-1:0]  ram_rdata;
	sum3_t              base;
	sum3_t              band_new;
	logic               fwd_hit;
	logic               emit;
	logic               res_fire;
	logic [OPTR_W+1:0]  occ_next;
	logic [SHIFT_W-1:0] avg_shift;
	bfd_result_t        result;

	// Line store of band sums, one entry per output column
	bfd_ram #(
		.WIDTH(BAND_W),
		.DEPTH(MAX_WIDTH)
	) u_band_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (op_s1.addr),
		.wdata (band_new),
		.re    (q_pop),
		.raddr (q_rdata.addr),
		.rdata (ram_rdata)
	);

	// Pop only when the result buffer is sure to have room
	assign res_fire = res_valid && !res_stall;
	assign emit     = valid_s1 && op_s1.row_last;
	assign occ_next = (OPTR_W + 2)'(ocount_q) + (OPTR_W + 2)'(emit)
	                - (OPTR_W + 2)'(res_fire);
	assign q_pop    = !q_empty && (occ_next < (OPTR_W + 2)'(OBUF_DEPTH));

	// Stage 1: line store read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_rdata;
		end
	end

	// Accumulate; a write from the cycle before is not yet in the read data
	assign fwd_hit = fwd_valid_q && (fwd_addr_q == op_s1.addr);
	always_comb begin
		if (op_s1.row_first) begin
			base = '0;
		end else if (fwd_hit) begin
			base = fwd_data_q;
		end else begin
			base = ram_rdata;
		end
		for (int k = 0; k < NUM_CH; k++) begin
			band_new[k] = base[k] + op_s1.hsum[k];
		end
	end

	// Forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fwd_addr_q <= op_s1.addr;
			fwd_data_q <= band_new;
		end
	end

	// Mean is the block sum shifted by twice the level
	assign avg_shift = {1'b0, op_s1.lv} << 1;
	always_comb begin
		for (int k = 0; k < NUM_CH; k++) begin
			result.avg[k] = PIX_W'(band_new[k] >> avg_shift);
		end
		result.col  = COL_W'(op_s1.addr);
		result.row  = op_s1.orow;
		result.last = op_s1.last;
	end

	// Result buffer
	always_ff @(posedge clk) begin
		if (emit) begin
			obuf_q[owr_ptr_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocount_q  <= '0;
		end else begin
			if (emit) begin
				owr_ptr_q <= owr_ptr_q + OPTR_W'(1);
			end
			if (res_fire) begin
				ord_ptr_q <= ord_ptr_q + OPTR_W'(1);
			end
			ocount_q <= occ_next[OPTR_W:0];
		end
	end

	assign res_valid = ocount_q != '0;
	assign res_word  = obuf_q[ord_ptr_q];

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for box_filter_downsample
// Streams RGB source pixels through the block under several register
// settings and checks every output pixel (block means, position and end of
// image flag) against an in-bench model of the downsampler. Source gaps and
// result stalls are random; registers change only while the block is idle.
// ---------------------------------------------------------------------------

module tb_top import bfd_pkg::*;;

	localparam int PERIOD      = 20;
	localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
	localparam int SETTLE      = 12;     // result latency plus buffer margin
	localparam int RANDOM_PIX  = 300;

	// register index the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_ZERO, FILL_RAILS, FILL_NEAR_RAILS} fill_t;

	// Downsampler model plus queue of output pixels still owed by the block
	class downsample_board;
		int unsigned width_reg, height_reg, level_reg;
		int unsigned col_pos, row_pos;
		int unsigned run_sum [NUM_CH];
		int unsigned band [MAX_WIDTH][NUM_CH];
		bfd_result_t owed_q [$];
		int unsigned errors, checked, image_ends;

		function new();
			width_reg  = 1024;
			height_reg = 768;
			level_reg  = 1;
			col_pos    = 0;
			row_pos    = 0;
			errors     = 0;
			checked    = 0;
			image_ends = 0;
			foreach (run_sum[k]) run_sum[k] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_SRC_WIDTH)
				width_reg = data[WIDTH_W-1:0];
			else if (idx == CFG_SRC_HEIGHT)
				height_reg = data[HEIGHT_W-1:0];
			else if (idx == CFG_LEVEL)
				level_reg = data[LEVEL_W-1:0];
		endfunction

		function int unsigned eff_width();
			int unsigned w;
			w = (width_reg == 0) ? 1 : width_reg;
			return (w > MAX_WIDTH) ? MAX_WIDTH : w;
		endfunction

		function int unsigned eff_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int unsigned eff_level();
			return (level_reg > MAX_LEVEL) ? MAX_LEVEL : level_reg;
		endfunction

		function int unsigned waiting();
			return owed_q.size();
		endfunction

		// Fold one source pixel into the run and band sums
		function void take_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
				logic [PIX_W-1:0] b);
			int unsigned w, h, lv, mask, ow, oh, ocol, orow;
			int unsigned px [NUM_CH];
			bfd_result_t want;
			w    = eff_width();
			h    = eff_height();
			lv   = eff_level();
			mask = (1 << lv) - 1;
			ow   = w >> lv;
			oh   = h >> lv;
			ocol = col_pos >> lv;
			orow = row_pos >> lv;
			px[0] = r;
			px[1] = g;
			px[2] = b;

			// pixels outside the last whole block only advance the position
			if (ocol < ow && orow < oh) begin
				for (int k = 0; k < NUM_CH; k++) begin
					if ((col_pos & mask) == 0)
						run_sum[k] = px[k];
					else
						run_sum[k] += px[k];
				end
				if ((col_pos & mask) == mask) begin
					for (int k = 0; k < NUM_CH; k++) begin
						if ((row_pos & mask) == 0)
							band[ocol][k] = run_sum[k];
						else
							band[ocol][k] += run_sum[k];
					end
					if ((row_pos & mask) == mask) begin
						for (int k = 0; k < NUM_CH; k++)
							want.avg[k] = PIX_W'(band[ocol][k] >> (2 * lv));
						want.col  = COL_W'(ocol);
						want.row  = ROW_W'(orow);
						want.last = (ocol == ow - 1) && (orow == oh - 1);
						owed_q.push_back(want);
					end
				end
			end

			// raster position, wrapping at row and image end
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		// Compare one output pixel with the oldest one owed
		function void take_result(bfd_result_t got);
			bfd_result_t want;
			bit bad;
			checked++;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb_top: output pixel col %0d row %0d with none expected",
						got.col, got.row);
				return;
			end
			want = owed_q.pop_front();
			if (want.last)
				image_ends++;
			bad = 1'b0;
			for (int k = 0; k < NUM_CH; k++)
				if (got.avg[k] !== want.avg[k])
					bad = 1'b1;
			if (got.col !== want.col || got.row !== want.row || got.last !== want.last)
				bad = 1'b1;
			if (bad) begin
				errors++;
				if (errors <= 10) begin
					$display("tb_top: mismatch, expected rgb %0d %0d %0d col %0d row %0d last %0d",
						want.avg[0], want.avg[1], want.avg[2], want.col, want.row, want.last);
					$display("tb_top:                got rgb %0d %0d %0d col %0d row %0d last %0d",
						got.avg[0], got.avg[1], got.avg[2], got.col, got.row, got.last);
				end
			end
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	logic [PIX_W-1:0]      red       = '0;
	logic [PIX_W-1:0]      green     = '0;
	logic [PIX_W-1:0]      blue      = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [PIX_W-1:0]      avg_red, avg_green, avg_blue;
	logic [COL_W-1:0]      out_col;
	logic [ROW_W-1:0]      out_row;
	logic                  last_of_image;

	downsample_board board;
	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	int stall_left = 0;
	int quiet      = 0;
	int pixels_in  = 0;
	int reg_writes = 0;
	int settings   = 0;

	box_filter_downsample DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.avg_red       (avg_red),
		.avg_green     (avg_green),
		.avg_blue      (avg_blue),
		.out_col       (out_col),
		.out_row       (out_row),
		.last_of_image (last_of_image)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Result side: check accepted words, then pick the next stall
	always @(posedge clk) begin
		bfd_result_t got;
		if (res_valid && !res_stall) begin
			got.avg[0] = avg_red;
			got.avg[1] = avg_green;
			got.avg[2] = avg_blue;
			got.col    = out_col;
			got.row    = out_row;
			got.last   = last_of_image;
			board.take_result(got);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall  <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 9) == 0) begin
			stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 3);
			res_stall  <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Watchdog: any handshake counts as progress
	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [PIX_W-1:0] pick_value(fill_t fill);
		case (fill)
			FILL_MAX:        return '1;
			FILL_ZERO:       return '0;
			FILL_RAILS:      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			FILL_NEAR_RAILS: return $urandom_range(0, 1) ? 8'(252 + $urandom_range(0, 3))
				: 8'($urandom_range(0, 3));
			default:         return 8'($urandom);
		endcase
	endfunction

	// One source pixel, after an optional gap
	task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		board.take_pixel(r, g, b);
		pixels_in++;
	endtask

	task automatic send_burst(input int count, input fill_t fill);
		for (int i = 0; i < count; i++)
			send_pixel(pick_value(fill), pick_value(fill), pick_value(fill));
	endtask

	// Stop sending and wait until every owed output pixel is out
	task automatic settle();
		pix_valid <= 1'b0;
		while (board.waiting() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
		reg_writes++;
	endtask

	// Width and level data carry random noise above their fields
	task automatic set_regs(input int unsigned w, input int unsigned h, input int unsigned lv);
		settle();
		write_reg(CFG_SRC_WIDTH, {4'($urandom), 12'(w)});
		write_reg(CFG_SRC_HEIGHT, 16'(h));
		write_reg(CFG_LEVEL, {13'($urandom), 3'(lv)});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Random setting, sized so that most phases stay small
	task automatic random_phase();
		int unsigned lv, lv_eff, blk, w, h, size, count;
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			lv = $urandom_range(5, 7);
		else if (r <= 2)
			lv = MAX_LEVEL;
		else
			lv = $urandom_range(0, 3);
		lv_eff = (lv > MAX_LEVEL) ? MAX_LEVEL : lv;
		blk = 1 << lv_eff;

		r = $urandom_range(0, 19);
		if (r == 0)
			w = 0;
		else if (r == 1)
			w = $urandom_range(MAX_WIDTH, 4095);
		else
			w = blk * $urandom_range(1, (lv_eff >= 3) ? 2 : 5) + $urandom_range(0, blk - 1);

		r = $urandom_range(0, 19);
		if (r == 0)
			h = 0;
		else if (r == 1)
			h = $urandom_range(0, 65535);
		else
			h = blk * $urandom_range(1, (lv_eff >= 3) ? 2 : 4) + $urandom_range(0, blk - 1);

		settle();
		// mostly all three registers, sometimes a subset
		if ($urandom_range(0, 4) != 0)
			write_reg(CFG_SRC_WIDTH, {4'($urandom), 12'(w)});
		if ($urandom_range(0, 4) != 0)
			write_reg(CFG_SRC_HEIGHT, 16'(h));
		if ($urandom_range(0, 4) != 0)
			write_reg(CFG_LEVEL, {13'($urandom), 3'(lv)});
		cfg_valid <= 1'b0;
		settings++;

		gaps_on   = ($urandom_range(0, 3) != 0);
		stalls_on = ($urandom_range(0, 3) != 0);

		// whole images mostly; a partial count leaves the next write mid-image
		size = board.eff_width() * board.eff_height();
		if (size > 600)
			count = $urandom_range(1, 150);
		else if ($urandom_range(0, 4) == 0)
			count = $urandom_range(1, size);
		else
			count = size * $urandom_range(1, 2);

		r = $urandom_range(0, 9);
		send_burst(count, (r < 6) ? FILL_RANDOM : (r == 6) ? FILL_MAX : (r == 7) ? FILL_ZERO
			: (r == 8) ? FILL_RAILS : FILL_NEAR_RAILS);
	endtask

	initial begin
		int random_start;
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Settings from reset: one row of 1024 at level 1
		send_burst(1024, FILL_RANDOM);

		// Width write mid-image, level and height kept from reset: row 1 closes
		// the first 128 blocks begun in row 0
		settle();
		write_reg(CFG_SRC_WIDTH, {4'($urandom), 12'hFFF});
		cfg_valid <= 1'b0;
		settings++;
		send_burst(256, FILL_RANDOM);

		// Zero width and height mean one pixel; every pixel ends an image
		set_regs(0, 0, 0);
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid <= 1'b0;
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hAA, 8'h55, 8'h0F);
		send_pixel(8'h55, 8'hAA, 8'hF0);

		// Level beyond the limit: image smaller than one block gives nothing
		set_regs(3, 3, 7);
		send_burst(9, FILL_RANDOM);

		// Odd size at level 1: last column and row dropped
		set_regs(3, 3, 1);
		send_burst(9, FILL_MAX);

		// Largest block of full-scale pixels
		set_regs(16, 16, MAX_LEVEL);
		send_burst(256, FILL_MAX);

		random_start = pixels_in;
		while (pixels_in - random_start < RANDOM_PIX)
			random_phase();

		settle();
		$display("tb_top: %0d source pixels under %0d settings, %0d register writes",
			pixels_in, settings, reg_writes);
		$display("tb_top: %0d output pixels compared, %0d of them closing an image",
			board.checked, board.image_ends);
		if (board.errors == 0 && board.waiting() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: %0d mismatches, %0d output pixels never seen",
				board.errors, board.waiting());
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ----- box_filter_downsample.f -----
rtl/core/bfd_pkg.sv
rtl/core/bfd_ram.sv
rtl/core/bfd_front.sv
rtl/core/bfd_queue.sv
rtl/core/bfd_back.sv
rtl/core/box_filter_downsample.sv
bench/tb_top.sv
